/* src/mrm_pkg.sv */
// ----------------------------------------------------------------------------
// mrm_pkg
// Shared widths, reset values, message codes and types of the mouse report
// to MIDI translator.
// ----------------------------------------------------------------------------
package mrm_pkg;

	localparam int BTN_W     = 3;
	localparam int DELTA_W   = 8;
	localparam int POS_W     = 10;
	localparam int DATA_W    = 7;
	localparam int SENT_W    = 8;
	localparam int CFG_IDX_W = 3;
	localparam int SLOTS     = 5;

	localparam logic [POS_W-1:0]  POS_RESET  = POS_W'(511);
	localparam logic [POS_W-1:0]  POS_MAX    = POS_W'(1023);
	localparam logic [SENT_W-1:0] SENT_NONE  = SENT_W'(255);
	localparam logic [DATA_W-1:0] VEL_ON     = DATA_W'(127);
	localparam logic [DATA_W-1:0] VEL_OFF    = '0;

	localparam logic [DATA_W-1:0] LEFT_NOTE_RST   = DATA_W'(60);
	localparam logic [DATA_W-1:0] RIGHT_NOTE_RST  = DATA_W'(61);
	localparam logic [DATA_W-1:0] MIDDLE_NOTE_RST = DATA_W'(62);
	localparam logic [DATA_W-1:0] X_CTRL_RST      = DATA_W'(71);
	localparam logic [DATA_W-1:0] Y_CTRL_RST      = DATA_W'(72);

	localparam int QUEUE_DEPTH = 2;

	// message slots of one report, in emission order
	localparam int SLOT_LEFT   = 0;
	localparam int SLOT_RIGHT  = 1;
	localparam int SLOT_MIDDLE = 2;
	localparam int SLOT_CC_X   = 3;
	localparam int SLOT_CC_Y   = 4;

	// message_kind codes: note-on (0x90), control change (0xB0)
	localparam logic KIND_NOTE = 1'b0;
	localparam logic KIND_CC   = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEFT_NOTE   = 3'd0,
		REG_RIGHT_NOTE  = 3'd1,
		REG_MIDDLE_NOTE = 3'd2,
		REG_X_CTRL      = 3'd3,
		REG_Y_CTRL      = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [DATA_W-1:0] left_note;
		logic [DATA_W-1:0] right_note;
		logic [DATA_W-1:0] middle_note;
		logic [DATA_W-1:0] x_controller;
		logic [DATA_W-1:0] y_controller;
	} cfg_t;

	// one classified report: which messages to send and their values
	typedef struct packed {
		logic [SLOTS-1:0]  mask;
		logic [BTN_W-1:0]  buttons;
		logic [DATA_W-1:0] cc_x;
		logic [DATA_W-1:0] cc_y;
	} job_t;

endpackage

/* src/mrm_report_if.sv */
// ----------------------------------------------------------------------------
// mrm_report_if
// Mouse report channel: valid/ready with button bits and signed deltas.
// ----------------------------------------------------------------------------
interface mrm_report_if import mrm_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [BTN_W-1:0]          button_bits;
	logic signed [DELTA_W-1:0] delta_x;
	logic signed [DELTA_W-1:0] delta_y;

	modport source(output valid, button_bits, delta_x, delta_y, input ready);
	modport sink(input valid, button_bits, delta_x, delta_y, output ready);
endinterface

/* src/mrm_midi_if.sv */
// ----------------------------------------------------------------------------
// mrm_midi_if
// MIDI message channel: valid/ready with one short message per word.
// ----------------------------------------------------------------------------
interface mrm_midi_if import mrm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              message_kind;
	logic [DATA_W-1:0] first_data;
	logic [DATA_W-1:0] second_data;
	logic              last_of_run;

	modport source(output valid, message_kind, first_data, second_data, last_of_run,
		input ready);
	modport sink(input valid, message_kind, first_data, second_data, last_of_run,
		output ready);
endinterface

/* src/mrm_cfg_if.sv */
// ----------------------------------------------------------------------------
// mrm_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface mrm_cfg_if import mrm_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DATA_W-1:0]    data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* src/mrm_front.sv */
// ----------------------------------------------------------------------------
// mrm_front
// Accepts mouse reports, tracks buttons, positions and last sent controller
// values, and queues a job for every report that causes messages.
// ----------------------------------------------------------------------------
module mrm_front import mrm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	mrm_report_if.sink  report,
	input  logic        full,
	output logic        push,
	output job_t        push_job
);

	logic [BTN_W-1:0]  held_q;
	logic [POS_W-1:0]  pos_x_q, pos_y_q;
	logic [SENT_W-1:0] sent_x_q, sent_y_q;

	logic [POS_W-1:0]  pos_x_nx, pos_y_nx;
	logic [DATA_W-1:0] cc_x, cc_y;
	logic              fire;

	function automatic logic [POS_W-1:0] move_axis(input logic [POS_W-1:0] pos,
		input logic signed [DELTA_W-1:0] d);
		logic signed [POS_W+1:0] sum;
		sum = $signed({2'b00, pos}) + (POS_W+2)'(d);
		if (sum[POS_W+1])
			return '0;
		else if (sum[POS_W])
			return POS_MAX;
		else
			return sum[POS_W-1:0];
	endfunction

	assign report.ready = !full;
	assign fire         = report.valid && report.ready;

	always_comb begin
		pos_x_nx = move_axis(pos_x_q, report.delta_x);
		pos_y_nx = move_axis(pos_y_q, report.delta_y);
		cc_x     = pos_x_nx[POS_W-1:POS_W-DATA_W];
		cc_y     = pos_y_nx[POS_W-1:POS_W-DATA_W];

		push_job.buttons = report.button_bits;
		push_job.cc_x    = cc_x;
		push_job.cc_y    = cc_y;
		push_job.mask    = {({1'b0, cc_y} != sent_y_q), ({1'b0, cc_x} != sent_x_q),
			report.button_bits ^ held_q};
		// drop reports that change nothing
		push = fire && (|push_job.mask);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= '0;
			pos_x_q  <= POS_RESET;
			pos_y_q  <= POS_RESET;
			sent_x_q <= SENT_NONE;
			sent_y_q <= SENT_NONE;
		end else if (fire) begin
			held_q   <= report.button_bits;
			pos_x_q  <= pos_x_nx;
			pos_y_q  <= pos_y_nx;
			sent_x_q <= {1'b0, cc_x};
			sent_y_q <= {1'b0, cc_y};
		end
	end

endmodule

/* src/mrm_queue.sv */
// ----------------------------------------------------------------------------
// mrm_queue
// Short job queue between the report front and the message back.
// ----------------------------------------------------------------------------
module mrm_queue import mrm_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output job_t head,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(DEPTH - 1))
			return '0;
		else
			return p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= advance(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= advance(rd_ptr_q);
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

/* src/mrm_back.sv */
// ----------------------------------------------------------------------------
// mrm_back
// Walks the pending message slots of one job in fixed order and drives one
// MIDI message per word through an output register.
// ----------------------------------------------------------------------------
module mrm_back import mrm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        empty,
	input  job_t        head,
	output logic        pop,
	mrm_midi_if.source  midi
);

	job_t              job_q;
	logic [SLOTS-1:0]  mask_q;
	logic              out_valid_q, out_kind_q, out_last_q;
	logic [DATA_W-1:0] out_first_q, out_second_q;

	logic              adv, have, emit;
	logic [SLOTS-1:0]  pick, rest;
	logic              sel_kind;
	logic [DATA_W-1:0] sel_first, sel_second;

	always_comb begin
		adv  = !out_valid_q || midi.ready;
		have = |mask_q;
		emit = adv && have;
		pick = mask_q & (~mask_q + 1'b1);
		rest = mask_q & ~pick;
		// load the next job once the current one is done or leaves now
		pop  = !empty && (!have || (emit && rest == '0));

		sel_kind   = KIND_CC;
		sel_first  = cfg.y_controller;
		sel_second = job_q.cc_y;
		if (mask_q[SLOT_LEFT]) begin
			sel_kind   = KIND_NOTE;
			sel_first  = cfg.left_note;
			sel_second = job_q.buttons[SLOT_LEFT] ? VEL_ON : VEL_OFF;
		end else if (mask_q[SLOT_RIGHT]) begin
			sel_kind   = KIND_NOTE;
			sel_first  = cfg.right_note;
			sel_second = job_q.buttons[SLOT_RIGHT] ? VEL_ON : VEL_OFF;
		end else if (mask_q[SLOT_MIDDLE]) begin
			sel_kind   = KIND_NOTE;
			sel_first  = cfg.middle_note;
			sel_second = job_q.buttons[SLOT_MIDDLE] ? VEL_ON : VEL_OFF;
		end else if (mask_q[SLOT_CC_X]) begin
			sel_kind   = KIND_CC;
			sel_first  = cfg.x_controller;
			sel_second = job_q.cc_x;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop)
				mask_q <= head.mask;
			else if (emit)
				mask_q <= rest;
			if (adv)
				out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			job_q <= head;
		if (emit) begin
			out_kind_q   <= sel_kind;
			out_first_q  <= sel_first;
			out_second_q <= sel_second;
			out_last_q   <= (rest == '0);
		end
	end

	assign midi.valid        = out_valid_q;
	assign midi.message_kind = out_kind_q;
	assign midi.first_data   = out_first_q;
	assign midi.second_data  = out_second_q;
	assign midi.last_of_run  = out_last_q;

endmodule

/* src/mouse_report_to_midi.sv */
// ----------------------------------------------------------------------------
// mouse_report_to_midi
// Turns boot-protocol mouse reports into MIDI note-on and control change words.
// ----------------------------------------------------------------------------
// A report is taken whenever the job queue has room (a queue of
// QUEUE_DEPTH jobs), so reports may arrive back to back. Each report causes
// zero to five MIDI words: a note-on per changed button (left, right, middle),
// then a control change for X and for Y when position>>3 moved; the final word
// of a report carries last_of_run. A report that changes nothing leaves no
// word. The back end sends one word per cycle through its output register
// while the output channel is ready. Configuration writes are always ready
// and take effect on the next cycle; write them only while idle.
// ----------------------------------------------------------------------------
module mouse_report_to_midi import mrm_pkg::*; #(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	mrm_report_if.sink   report,
	mrm_midi_if.source   midi,
	mrm_cfg_if.sink      cfg
);

	cfg_t cfg_q;
	logic push, full, pop, empty;
	job_t push_job, head;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left_note    <= LEFT_NOTE_RST;
			cfg_q.right_note   <= RIGHT_NOTE_RST;
			cfg_q.middle_note  <= MIDDLE_NOTE_RST;
			cfg_q.x_controller <= X_CTRL_RST;
			cfg_q.y_controller <= Y_CTRL_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LEFT_NOTE:   cfg_q.left_note    <= cfg.data;
				REG_RIGHT_NOTE:  cfg_q.right_note   <= cfg.data;
				REG_MIDDLE_NOTE: cfg_q.middle_note  <= cfg.data;
				REG_X_CTRL:      cfg_q.x_controller <= cfg.data;
				REG_Y_CTRL:      cfg_q.y_controller <= cfg.data;
				default: ;
			endcase
		end
	end

	mrm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.report   (report),
		.full     (full),
		.push     (push),
		.push_job (push_job)
	);

	mrm_queue #(.DEPTH(QUEUE_DEPTH_P)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	mrm_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.midi   (midi)
	);

endmodule

/* src/mrm_chk.sv */
// ----------------------------------------------------------------------------
// mrm_chk
// Port-level checks of the translator, bound to the top level.
// ----------------------------------------------------------------------------
module mrm_chk import mrm_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic              message_kind,
	input logic [DATA_W-1:0] first_data,
	input logic [DATA_W-1:0] second_data,
	input logic              last_of_run
);

	logic        in_fire, run_end;
	logic [31:0] open_q;
	logic        seen_q;

	assign in_fire = in_valid && in_ready;
	assign run_end = out_valid && out_ready && last_of_run;

	// reports taken minus runs finished
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
			seen_q <= 1'b0;
		end else begin
			if (in_fire)
				seen_q <= 1'b1;
			if (in_fire && !run_end)
				open_q <= open_q + 1'b1;
			else if (run_end && !in_fire)
				open_q <= open_q - 1'b1;
		end
	end

	a_no_word_before_report: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> seen_q)
		else $error("word shown before any report was taken");

	a_run_has_report: assert property (@(posedge clk) disable iff (!arst_n)
		run_end |-> (open_q != '0))
		else $error("more runs finished than reports taken");

	a_note_velocity: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && message_kind == KIND_NOTE) |->
		(second_data == VEL_ON || second_data == VEL_OFF))
		else $error("note-on velocity is neither full nor zero");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(message_kind) &&
		$stable(first_data) && $stable(second_data) && $stable(last_of_run)))
		else $error("stalled word changed");

endmodule

bind mouse_report_to_midi mrm_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (report.valid),
	.in_ready     (report.ready),
	.out_valid    (midi.valid),
	.out_ready    (midi.ready),
	.message_kind (midi.message_kind),
	.first_data   (midi.first_data),
	.second_data  (midi.second_data),
	.last_of_run  (midi.last_of_run)
);
